// ===== design/mc2dlb_pkg.sv =====
// Package: shared constants, widths and codes for the multichannel 2D convolution core.
`timescale 1ns / 1ps

package mc2dlb_pkg;

    // Kernel and frame geometry
    localparam int KERNEL     = 3;
    localparam int CHANNELS   = 3;
    localparam int MAX_WIDTH  = 1024;
    localparam int ROW_LIMIT  = 1024;

    localparam int COEF_SLOTS = CHANNELS * KERNEL * KERNEL;

    // Counter and store widths
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(ROW_LIMIT);
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SLOT_W = (KERNEL > 1) ? $clog2(KERNEL) : 1;
    localparam int MEM_DEPTH = CHANNELS * MAX_WIDTH;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    // Configuration port
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int CNT_W     = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
    localparam int RCNT_W    = (ROW_W + 1 > CFG_W) ? ROW_W + 1 : CFG_W;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;
    localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

    // Payload fields
    localparam int PIX_W    = 8;
    localparam int CIDX_W   = 5;
    localparam int COEF_W   = 16;
    localparam int PROD_W   = PIX_W + 1 + COEF_W;
    localparam int SUM_W    = 32;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 32;

    // Input transaction kind
    typedef enum logic [0:0] {
        OP_PIXEL = 1'b0,
        OP_COEF  = 1'b1
    } t_op;

endpackage

// ===== design/multichannel_conv2d_line_buffer_core.sv =====
// Top level: multichannel KxK convolution with per-channel line store and pipelined MAC tree.
`timescale 1ns / 1ps

//  Channel   | Direction | Handshake             | Payload
//  ----------+-----------+-----------------------+----------------------------------------
//  s_axis    | in        | tvalid / tready       | tdata: pixel, coef_index, coef_value
//            |           |                       | tuser: operation
//  m_axis    | out       | tvalid / tready       | tdata: conv_value; tuser: window_valid
//            |           |                       | tlast: frame_last
//  cfg       | in        | i_cfg_we              | i_cfg_index, i_cfg_wdata
//
//  One transaction per cycle is taken while s_axis_tready is high. A result is
//  registered through the line-store read, the window shift, the multiplier
//  stage and a three-level adder tree before it leaves the output register.
//  Reset (synchronous) clears counters, coefficients and sets 640x480; the line
//  store is not cleared. A stall on m_axis fills pipeline bubbles first and
//  reaches s_axis_tready only once every stage holds a transaction.
module multichannel_conv2d_line_buffer_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config port
    input  logic                              i_cfg_we,
    input  logic [mc2dlb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mc2dlb_pkg::CFG_W-1:0]      i_cfg_wdata,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [7:0] pixel, [12:8] coef_index, [28:13] coef_value, [31:29] zero
    input  logic [mc2dlb_pkg::S_DATA_W-1:0]   s_axis_tdata,
    // [0] operation
    input  logic                              s_axis_tuser,
    // output stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [31:0] conv_value
    output logic [mc2dlb_pkg::M_DATA_W-1:0]   m_axis_tdata,
    // [0] window_valid
    output logic                              m_axis_tuser,
    output logic                              m_axis_tlast
);

    localparam int K   = mc2dlb_pkg::KERNEL;
    localparam int NCH = mc2dlb_pkg::CHANNELS;

    // ------------------------------------------------------------------
    // Configuration and coefficient registers
    // ------------------------------------------------------------------
    logic [mc2dlb_pkg::CFG_W-1:0] r_img_w, r_img_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= mc2dlb_pkg::WIDTH_RESET;
            r_img_h <= mc2dlb_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mc2dlb_pkg::REG_IMAGE_WIDTH:  r_img_w <= i_cfg_wdata;
                mc2dlb_pkg::REG_IMAGE_HEIGHT: r_img_h <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Clamp width to 1..MAX_WIDTH and height to 1..ROW_LIMIT
    logic [mc2dlb_pkg::CNT_W-1:0]  eff_w;
    logic [mc2dlb_pkg::RCNT_W-1:0] eff_h;

    always_comb begin
        if (r_img_w == '0)
            eff_w = mc2dlb_pkg::CNT_W'(1);
        else if (mc2dlb_pkg::CNT_W'(r_img_w) > mc2dlb_pkg::CNT_W'(mc2dlb_pkg::MAX_WIDTH))
            eff_w = mc2dlb_pkg::CNT_W'(mc2dlb_pkg::MAX_WIDTH);
        else
            eff_w = mc2dlb_pkg::CNT_W'(r_img_w);

        if (r_img_h == '0)
            eff_h = mc2dlb_pkg::RCNT_W'(1);
        else if (mc2dlb_pkg::RCNT_W'(r_img_h) > mc2dlb_pkg::RCNT_W'(mc2dlb_pkg::ROW_LIMIT))
            eff_h = mc2dlb_pkg::RCNT_W'(mc2dlb_pkg::ROW_LIMIT);
        else
            eff_h = mc2dlb_pkg::RCNT_W'(r_img_h);
    end

    // ------------------------------------------------------------------
    // Pipeline handshake
    // ------------------------------------------------------------------
    logic r1_valid, r2_valid, r3_valid, r4_valid, r5_valid, r_out_valid;
    logic en1, en2, en3, en4, en5, en_out;
    logic in_fire;

    assign en_out = !r_out_valid || m_axis_tready;
    assign en5    = !r5_valid || en_out;
    assign en4    = !r4_valid || en5;
    assign en3    = !r3_valid || en4;
    assign en2    = !r2_valid || en3;
    assign en1    = !r1_valid || en2;

    assign s_axis_tready = en1;
    assign in_fire       = s_axis_tvalid && en1;

    // Input field unpack
    mc2dlb_pkg::t_op                      in_op;
    logic [mc2dlb_pkg::PIX_W-1:0]         in_pixel;
    logic [mc2dlb_pkg::CIDX_W-1:0]        in_cidx;
    logic signed [mc2dlb_pkg::COEF_W-1:0] in_cval;

    assign in_op    = mc2dlb_pkg::t_op'(s_axis_tuser);
    assign in_pixel = s_axis_tdata[7:0];
    assign in_cidx  = s_axis_tdata[12:8];
    assign in_cval  = s_axis_tdata[28:13];

    // ------------------------------------------------------------------
    // Raster counters (advance on accepted pixel samples)
    // ------------------------------------------------------------------
    logic [mc2dlb_pkg::COL_W-1:0]  r_col, n_col, col_cur;
    logic [mc2dlb_pkg::ROW_W-1:0]  r_row, n_row;
    logic [mc2dlb_pkg::CH_W-1:0]   r_ch, n_ch, ch_cur;
    logic [mc2dlb_pkg::SLOT_W-1:0] r_slot, n_slot;
    logic                          last_ch, col_end, row_end, win_ok, frame_last;
    logic [mc2dlb_pkg::MEM_AW-1:0] mem_addr;

    always_comb begin
        ch_cur  = (int'(r_ch) >= NCH) ? '0 : r_ch;
        col_cur = (int'(r_col) >= mc2dlb_pkg::MAX_WIDTH) ?
                  mc2dlb_pkg::COL_W'(mc2dlb_pkg::MAX_WIDTH - 1) : r_col;
        last_ch = (int'(ch_cur) == NCH - 1);
        col_end = (mc2dlb_pkg::CNT_W'(col_cur) + mc2dlb_pkg::CNT_W'(1)) >= eff_w;
        row_end = (mc2dlb_pkg::RCNT_W'(r_row) + mc2dlb_pkg::RCNT_W'(1)) >= eff_h;
        win_ok  = (int'(r_row) >= K - 1) && (int'(col_cur) >= K - 1);
        frame_last = col_end && row_end;
        mem_addr = mc2dlb_pkg::MEM_AW'(mc2dlb_pkg::MEM_AW'(ch_cur) *
                   mc2dlb_pkg::MEM_AW'(mc2dlb_pkg::MAX_WIDTH) +
                   mc2dlb_pkg::MEM_AW'(col_cur));

        n_ch   = r_ch;
        n_col  = r_col;
        n_row  = r_row;
        n_slot = r_slot;
        if (in_fire && in_op == mc2dlb_pkg::OP_PIXEL) begin
            n_col = col_cur;
            if (!last_ch) begin
                n_ch = mc2dlb_pkg::CH_W'(ch_cur + 1'b1);
            end else begin
                n_ch = '0;
                if (col_end) begin
                    n_col = '0;
                    if (row_end) begin
                        n_row  = '0;
                        n_slot = '0;
                    end else begin
                        n_row  = r_row + 1'b1;
                        n_slot = (int'(r_slot) == K - 1) ? '0 : r_slot + 1'b1;
                    end
                end else begin
                    n_col = col_cur + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_ch   <= '0;
            r_slot <= '0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_ch   <= n_ch;
            r_slot <= n_slot;
        end
    end

    // ------------------------------------------------------------------
    // Line store: one memory per row slot, addressed by {channel, column}.
    // The current slot is written; the other slots are read for older rows.
    // ------------------------------------------------------------------
    logic [mc2dlb_pkg::PIX_W-1:0] r1_line [K];

    for (genvar s = 0; s < K; s++) begin : g_line
        logic [mc2dlb_pkg::PIX_W-1:0] mem [mc2dlb_pkg::MEM_DEPTH];

        always_ff @(posedge i_clk) begin
            if (in_fire && in_op == mc2dlb_pkg::OP_PIXEL && int'(r_slot) == s) begin
                mem[mem_addr] <= in_pixel;
            end
            if (en1) begin
                r1_line[s] <= mem[mem_addr];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: registered transaction
    // ------------------------------------------------------------------
    mc2dlb_pkg::t_op                      r1_op;
    logic [mc2dlb_pkg::PIX_W-1:0]         r1_pixel;
    logic [mc2dlb_pkg::CIDX_W-1:0]        r1_cidx;
    logic signed [mc2dlb_pkg::COEF_W-1:0] r1_cval;
    logic [mc2dlb_pkg::CH_W-1:0]          r1_ch;
    logic [mc2dlb_pkg::SLOT_W-1:0]        r1_slot;
    logic                                 r1_last_ch, r1_win_ok, r1_frame_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en1) begin
            r1_valid <= in_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r1_op         <= in_op;
            r1_pixel      <= in_pixel;
            r1_cidx       <= in_cidx;
            r1_cval       <= in_cval;
            r1_ch         <= ch_cur;
            r1_slot       <= r_slot;
            r1_last_ch    <= last_ch;
            r1_win_ok     <= win_ok;
            r1_frame_last <= frame_last;
        end
    end

    // Modular add on row slots; sum stays below 2*KERNEL
    function automatic logic [mc2dlb_pkg::SLOT_W-1:0] slot_add(
        input logic [mc2dlb_pkg::SLOT_W-1:0] base,
        input int                            off
    );
        logic [mc2dlb_pkg::SLOT_W:0] sum;
        sum = (mc2dlb_pkg::SLOT_W+1)'(base) + (mc2dlb_pkg::SLOT_W+1)'(off);
        if (int'(sum) >= K)
            sum = sum - (mc2dlb_pkg::SLOT_W+1)'(K);
        return sum[mc2dlb_pkg::SLOT_W-1:0];
    endfunction

    // New window column: oldest row first, current sample last
    logic [mc2dlb_pkg::PIX_W-1:0] w_newcol [K];

    always_comb begin
        for (int r = 0; r < K - 1; r++) begin
            w_newcol[r] = r1_line[slot_add(r1_slot, r + 1)];
        end
        w_newcol[K-1] = r1_pixel;
    end

    // Window registers per channel; column K-1 is the current column
    logic [mc2dlb_pkg::PIX_W-1:0]         r_win  [NCH][K][K];
    logic signed [mc2dlb_pkg::COEF_W-1:0] r_coef [mc2dlb_pkg::COEF_SLOTS];
    logic                                 s1_move;

    assign s1_move = en2 && r1_valid;

    always_ff @(posedge i_clk) begin
        if (s1_move && r1_op == mc2dlb_pkg::OP_PIXEL) begin
            for (int k = 0; k < NCH; k++) begin
                if (int'(r1_ch) == k) begin
                    for (int r = 0; r < K; r++) begin
                        for (int c = 0; c < K - 1; c++) begin
                            r_win[k][r][c] <= r_win[k][r][c+1];
                        end
                        r_win[k][r][K-1] <= w_newcol[r];
                    end
                end
            end
        end
    end

    // Coefficient writes take effect in transaction order with the pixels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mc2dlb_pkg::COEF_SLOTS; i++) begin
                r_coef[i] <= '0;
            end
        end else if (s1_move && r1_op == mc2dlb_pkg::OP_COEF) begin
            for (int i = 0; i < mc2dlb_pkg::COEF_SLOTS; i++) begin
                if (int'(r1_cidx) == i) begin
                    r_coef[i] <= r1_cval;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: result marker (window already shifted)
    // ------------------------------------------------------------------
    logic r2_win_ok, r2_frame_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en2) begin
            r2_valid <= r1_valid && r1_op == mc2dlb_pkg::OP_PIXEL && r1_last_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_win_ok     <= r1_win_ok;
            r2_frame_last <= r1_frame_last;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: one multiplier per window tap
    // ------------------------------------------------------------------
    logic signed [mc2dlb_pkg::PROD_W-1:0] r3_prod [NCH][K][K];
    logic                                 r3_win_ok, r3_frame_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en3) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3 && r2_valid) begin
            r3_win_ok     <= r2_win_ok;
            r3_frame_last <= r2_frame_last;
            for (int k = 0; k < NCH; k++) begin
                for (int r = 0; r < K; r++) begin
                    for (int c = 0; c < K; c++) begin
                        r3_prod[k][r][c] <= $signed({1'b0, r_win[k][r][c]}) *
                                            r_coef[(k * K + r) * K + c];
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: row sums; stage 5: channel sums; output: total
    // ------------------------------------------------------------------
    logic signed [mc2dlb_pkg::SUM_W-1:0] r4_row [NCH][K];
    logic signed [mc2dlb_pkg::SUM_W-1:0] n4_row [NCH][K];
    logic                                r4_win_ok, r4_frame_last;

    always_comb begin
        for (int k = 0; k < NCH; k++) begin
            for (int r = 0; r < K; r++) begin
                n4_row[k][r] = '0;
                for (int c = 0; c < K; c++) begin
                    n4_row[k][r] = n4_row[k][r] + mc2dlb_pkg::SUM_W'(r3_prod[k][r][c]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (en4) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4 && r3_valid) begin
            r4_row        <= n4_row;
            r4_win_ok     <= r3_win_ok;
            r4_frame_last <= r3_frame_last;
        end
    end

    logic signed [mc2dlb_pkg::SUM_W-1:0] r5_ch [NCH];
    logic signed [mc2dlb_pkg::SUM_W-1:0] n5_ch [NCH];
    logic                                r5_win_ok, r5_frame_last;

    always_comb begin
        for (int k = 0; k < NCH; k++) begin
            n5_ch[k] = '0;
            for (int r = 0; r < K; r++) begin
                n5_ch[k] = n5_ch[k] + r4_row[k][r];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (en5) begin
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en5 && r4_valid) begin
            r5_ch         <= n5_ch;
            r5_win_ok     <= r4_win_ok;
            r5_frame_last <= r4_frame_last;
        end
    end

    // Full-range sum stays well inside 32 bits, so no saturation is needed
    logic signed [mc2dlb_pkg::SUM_W-1:0] n_total;
    logic [mc2dlb_pkg::M_DATA_W-1:0]     r_out_data;
    logic                                r_out_win_ok, r_out_last;

    always_comb begin
        n_total = '0;
        for (int k = 0; k < NCH; k++) begin
            n_total = n_total + r5_ch[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_out) begin
            r_out_valid <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out && r5_valid) begin
            r_out_data   <= r5_win_ok ? mc2dlb_pkg::M_DATA_W'(n_total) : '0;
            r_out_win_ok <= r5_win_ok;
            r_out_last   <= r5_frame_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_win_ok;
    assign m_axis_tlast  = r_out_last;

endmodule
